>>> hw/rtl/spi_pkg.sv
// Shared types and constants for the scratch playhead interpolator.
// No dependencies; every other file in hw/rtl refers to this package by scoped name.
`default_nettype none

package spi_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int FRAME_W    = 2 * SAMPLE_W;
  localparam int KIND_W     = 3;
  localparam int SEED_W     = 33;
  localparam int HEAD_W     = 32;
  localparam int SPEED_W    = 24;
  localparam int GAIN_W     = 23;
  localparam int DECAY_W    = 17;
  localparam int MAXSPD_W   = 23;
  localparam int BAND_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int JOG_W      = 41;

  // Parameter defaults.
  localparam int HISTORY_DEPTH_DEF = 65536;
  localparam int FRAC_BITS_DEF     = 16;

  // Fixed arithmetic constants.
  localparam int                  DECAY_SHIFT = 16;
  localparam logic [SPEED_W-1:0]  SPEED_SAT   = 24'h7F_FFFF;
  localparam logic [HEAD_W-1:0]   HEAD_ALL    = 32'hFFFF_FFFF;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_JOG    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RENDER = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND  = 2'd3;

  // Configuration reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RST  = 23'd3277;
  localparam logic [DECAY_W-1:0]  DECAY_RST = 17'd65208;
  localparam logic [MAXSPD_W-1:0] MAX_RST   = 23'd262144;
  localparam logic [BAND_W-1:0]   BAND_RST  = 17'd655;

  // One result word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       audible;
    logic                       engaged;
    logic [HEAD_W-1:0]          head_position;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/spi_in_if.sv
// Input channel of the scratch playhead interpolator: valid/ready plus item fields.
// Depends on spi_pkg for field widths.
`default_nettype none

interface spi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [spi_pkg::KIND_W-1:0]           kind;
  logic signed [spi_pkg::SAMPLE_W-1:0]  push_left;
  logic signed [spi_pkg::SAMPLE_W-1:0]  push_right;
  logic signed [spi_pkg::SAMPLE_W-1:0]  jog_ticks;
  logic signed [spi_pkg::SEED_W-1:0]    seed_position;

  modport source (output valid, kind, push_left, push_right, jog_ticks, seed_position,
                  input ready);
  modport sink (input valid, kind, push_left, push_right, jog_ticks, seed_position,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spi_out_if.sv
// Result channel of the scratch playhead interpolator: valid/ready plus result fields.
// Depends on spi_pkg for field widths.
`default_nettype none

interface spi_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spi_pkg::SAMPLE_W-1:0]  left_out;
  logic signed [spi_pkg::SAMPLE_W-1:0]  right_out;
  logic                                 audible;
  logic                                 engaged;
  logic [spi_pkg::HEAD_W-1:0]           head_position;

  modport source (output valid, left_out, right_out, audible, engaged, head_position,
                  input ready);
  modport sink (input valid, left_out, right_out, audible, engaged, head_position,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spi_hist.sv
// Frame history memory: one write port and two registered read ports.
// Depends on spi_pkg for the frame width.
`default_nettype none

module spi_hist #(
  parameter int DEPTH = spi_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [spi_pkg::FRAME_W-1:0]  wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr0,
  input  logic [$clog2(DEPTH)-1:0]     raddr1,
  output logic [spi_pkg::FRAME_W-1:0]  rdata0,
  output logic [spi_pkg::FRAME_W-1:0]  rdata1
);

  logic [spi_pkg::FRAME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

>>> hw/rtl/spi_blend.sv
// Linear blend of two stereo frames: registered products, then sum and truncating divide.
// Depends on spi_pkg for sample and frame widths.
`default_nettype none

module spi_blend #(
  parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic [FRAC_BITS:0]                  frac,
  input  logic [spi_pkg::FRAME_W-1:0]         word0,
  input  logic [spi_pkg::FRAME_W-1:0]         word1,
  output logic signed [spi_pkg::SAMPLE_W-1:0] left,
  output logic signed [spi_pkg::SAMPLE_W-1:0] right
);

  localparam int SW_S = spi_pkg::SAMPLE_W;
  localparam int PW   = FRAC_BITS + SW_S + 2;
  localparam int SUMW = PW + 1;
  localparam logic [FRAC_BITS:0]       ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SUMW-1:0]   BIAS = SUMW'((1 << FRAC_BITS) - 1);

  logic [FRAC_BITS:0]       w0;
  logic signed [PW-1:0]     pl0_r, pl1_r, pr0_r, pr1_r;
  logic signed [SUMW-1:0]   sum_l, sum_r, adj_l, adj_r, q_l, q_r;

  assign w0 = ONE - frac;

  always_ff @(posedge clk) begin
    pl0_r <= $signed({1'b0, w0})   * $signed(word0[2*SW_S-1:SW_S]);
    pl1_r <= $signed({1'b0, frac}) * $signed(word1[2*SW_S-1:SW_S]);
    pr0_r <= $signed({1'b0, w0})   * $signed(word0[SW_S-1:0]);
    pr1_r <= $signed({1'b0, frac}) * $signed(word1[SW_S-1:0]);
  end

  // Division by one unit rounds toward zero, so negative sums are biased first.
  always_comb begin
    sum_l = SUMW'(pl0_r) + SUMW'(pl1_r);
    sum_r = SUMW'(pr0_r) + SUMW'(pr1_r);
    adj_l = sum_l[SUMW-1] ? sum_l + BIAS : sum_l;
    adj_r = sum_r[SUMW-1] ? sum_r + BIAS : sum_r;
    q_l   = adj_l >>> FRAC_BITS;
    q_r   = adj_r >>> FRAC_BITS;
    left  = q_l[SW_S-1:0];
    right = q_r[SW_S-1:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/spi_outq.sv
// Two-word result queue that parts the engine from the result channel.
// Depends on spi_pkg for the result word and on spi_out_if.
`default_nettype none

module spi_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  spi_pkg::res_t    push_data,
  output logic             room,
  spi_out_if.source        out_ch
);

  spi_pkg::res_t ent_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          pop;
  spi_pkg::res_t head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = (cnt_r != 2'd2);
  assign head = ent_r[rd_ptr_r];

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.left_out      = head.left_out;
  assign out_ch.right_out     = head.right_out;
  assign out_ch.audible       = head.audible;
  assign out_ch.engaged       = head.engaged;
  assign out_ch.head_position = head.head_position;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scratch_playhead_interpolator.sv
// Scratch playhead over a stored stereo frame history. Push, seed, end and a render while
// disengaged finish when taken; a jog passes through S_JOG, since the tick-times-gain
// product is registered before the add and clamp on the velocity. An engaged render runs
// window clamp, both bracketing frames read at once from the history memory's two read
// ports, blend products, then the sum and divide. Results leave through a two-word queue,
// so input words keep being taken while a result waits. The history memory is not cleared
// after reset; reads only ever reach frames already written, so there is no clearing pass.
// Depends on spi_pkg, spi_in_if, spi_out_if, spi_hist, spi_blend and spi_outq.
`default_nettype none

module scratch_playhead_interpolator #(
  parameter int HISTORY_DEPTH = spi_pkg::HISTORY_DEPTH_DEF,
  parameter int FRAC_BITS     = spi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  spi_in_if.sink                            in_ch,
  spi_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [spi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int MBX_W = (FW + FRAC_BITS > 32) ? FW + FRAC_BITS : 33;
  localparam int HW    = spi_pkg::HEAD_W;
  localparam int SPW   = spi_pkg::SPEED_W;
  localparam int DP_W  = spi_pkg::SPEED_W + spi_pkg::DECAY_W;
  localparam int JW    = spi_pkg::JOG_W;
  localparam logic [AW-1:0]      WP_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0]      FILL_FULL = FW'(HISTORY_DEPTH);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_JOG, S_R1, S_R2, S_R3} state_t;

  // Control state.
  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   wp_r, wp_nxt;
  logic [FW-1:0]                   fill_r, fill_nxt;
  logic [HW-1:0]                   head_r, head_nxt;
  logic signed [SPW-1:0]           speed_r, speed_nxt;
  logic                            scratch_r, scratch_nxt;
  logic [spi_pkg::GAIN_W-1:0]      gain_r;
  logic [spi_pkg::DECAY_W-1:0]     decay_r;
  logic [spi_pkg::MAXSPD_W-1:0]    max_r;
  logic [spi_pkg::BAND_W-1:0]      band_r;

  // Per-item working registers.
  logic [HW-1:0]                   hc_r, mb_r;
  logic                            few_r, stop_r, rim_r;
  logic signed [JW-2:0]            jprod_r;
  logic                            jz_r;
  logic [FRAC_BITS:0]              frac_r;
  logic [DP_W-1:0]                 dprod_r;
  logic signed [HW+1:0]            nh_r;

  // Window and mode decode from the current state.
  logic                            acc;
  logic [FW-1:0]                   fill_m1;
  logic [MBX_W-1:0]                mb_ext;
  logic [HW-1:0]                   max_back, hc;
  logic [SPW-1:0]                  spd_mag;
  logic                            spd_pos, spd_neg;

  // Frame addressing.
  logic [HW-1:0]                   k0_full;
  logic [FW-1:0]                   k0, k0a;
  logic                            at_top;
  logic [FRAC_BITS:0]              frac;
  logic [FW:0]                     t0, t1;
  logic [AW-1:0]                   raddr0, raddr1;

  // Velocity and head update.
  logic [DP_W-1:0]                 dsh;
  logic [SPW-1:0]                  dmag;
  logic signed [SPW-1:0]           decayed;
  logic [HW-1:0]                   nh_clamped;
  logic signed [JW-1:0]            jv, max_s;

  // Memory, blend and queue.
  logic [spi_pkg::FRAME_W-1:0]     rdata0, rdata1;
  logic signed [spi_pkg::SAMPLE_W-1:0] bl_left, bl_right;
  logic                            q_push, q_room, hist_we;
  spi_pkg::res_t                   q_data;

  assign in_ch.ready = (state_r == S_IDLE) && q_room;
  assign acc         = in_ch.valid && in_ch.ready;
  assign hist_we     = acc && (in_ch.kind == spi_pkg::KIND_PUSH);

  // The head is clamped into the window of stored frames before anything else.
  always_comb begin
    fill_m1  = fill_r - FW'(1);
    mb_ext   = MBX_W'(fill_m1) << FRAC_BITS;
    max_back = (mb_ext > MBX_W'(spi_pkg::HEAD_ALL)) ? spi_pkg::HEAD_ALL : mb_ext[HW-1:0];
    hc       = (head_r > max_back) ? max_back : head_r;
    spd_mag  = speed_r[SPW-1] ? SPW'(~speed_r + 1'b1) : SPW'(speed_r);
    spd_pos  = !speed_r[SPW-1] && (speed_r != '0);
    spd_neg  = speed_r[SPW-1];
  end

  // The oldest pair is used with a full fraction when the head sits at the top.
  always_comb begin
    k0_full = hc_r >> FRAC_BITS;
    k0      = FW'(k0_full);
    at_top  = (k0 >= fill_m1);
    k0a     = at_top ? fill_r - FW'(2) : k0;
    frac    = at_top ? ONE : {1'b0, hc_r[FRAC_BITS-1:0]};
    t0      = (FW+1)'(wp_r) - (FW+1)'(k0a) - (FW+1)'(1);
    t1      = t0 - (FW+1)'(1);
    raddr0  = t0[FW] ? AW'(t0 + (FW+1)'(HISTORY_DEPTH)) : AW'(t0);
    raddr1  = t1[FW] ? AW'(t1 + (FW+1)'(HISTORY_DEPTH)) : AW'(t1);
  end

  always_comb begin
    dsh        = dprod_r >> spi_pkg::DECAY_SHIFT;
    dmag       = (dsh > DP_W'(spi_pkg::SPEED_SAT)) ? spi_pkg::SPEED_SAT : dsh[SPW-1:0];
    decayed    = speed_r[SPW-1] ? $signed(~dmag + 1'b1) : $signed(dmag);
    if (nh_r[HW+1]) begin
      nh_clamped = '0;
    end else if (nh_r[HW:0] > {1'b0, mb_r}) begin
      nh_clamped = mb_r;
    end else begin
      nh_clamped = nh_r[HW-1:0];
    end
    max_s = $signed(JW'(max_r));
    jv    = JW'(speed_r) + JW'(jprod_r);
  end

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    head_nxt    = head_r;
    speed_nxt   = speed_r;
    scratch_nxt = scratch_r;
    q_push      = 1'b0;
    q_data      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          q_push = 1'b1;
          unique case (in_ch.kind)
            spi_pkg::KIND_PUSH: begin
              wp_nxt = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
              if (fill_r != FILL_FULL) begin
                fill_nxt = fill_r + FW'(1);
              end
            end
            spi_pkg::KIND_JOG: begin
              state_nxt = S_JOG;
            end
            spi_pkg::KIND_SEED: begin
              head_nxt    = in_ch.seed_position[spi_pkg::SEED_W-1] ? '0 :
                            in_ch.seed_position[HW-1:0];
              speed_nxt   = '0;
              scratch_nxt = 1'b1;
            end
            spi_pkg::KIND_END: begin
              speed_nxt   = '0;
              scratch_nxt = 1'b0;
            end
            spi_pkg::KIND_RENDER: begin
              if (scratch_r) begin
                q_push    = 1'b0;
                state_nxt = S_R1;
              end
            end
            default: begin
            end
          endcase
          q_data.engaged       = scratch_nxt;
          q_data.head_position = head_nxt;
        end
      end
      S_JOG: begin
        if (!jz_r) begin
          if (jv > max_s) begin
            speed_nxt = max_s[SPW-1:0];
          end else if (jv < -max_s) begin
            speed_nxt = SPW'(-max_s);
          end else begin
            speed_nxt = jv[SPW-1:0];
          end
        end
        state_nxt = S_IDLE;
      end
      S_R1: begin
        state_nxt = S_R2;
      end
      S_R2: begin
        if (few_r) begin
          speed_nxt = decayed;
        end else if (stop_r) begin
          speed_nxt = '0;
        end else begin
          head_nxt  = nh_clamped;
          speed_nxt = decayed;
        end
        state_nxt = S_R3;
      end
      S_R3: begin
        q_push = 1'b1;
        if (!few_r && !stop_r && !rim_r) begin
          q_data.left_out  = bl_left;
          q_data.right_out = bl_right;
          q_data.audible   = 1'b1;
        end
        q_data.engaged       = scratch_r;
        q_data.head_position = head_r;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      fill_r    <= '0;
      head_r    <= '0;
      speed_r   <= '0;
      scratch_r <= 1'b0;
      gain_r    <= spi_pkg::GAIN_RST;
      decay_r   <= spi_pkg::DECAY_RST;
      max_r     <= spi_pkg::MAX_RST;
      band_r    <= spi_pkg::BAND_RST;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      head_r    <= head_nxt;
      speed_r   <= speed_nxt;
      scratch_r <= scratch_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          spi_pkg::CFG_GAIN:  gain_r  <= cfg_wdata[spi_pkg::GAIN_W-1:0];
          spi_pkg::CFG_DECAY: decay_r <= cfg_wdata[spi_pkg::DECAY_W-1:0];
          spi_pkg::CFG_MAX:   max_r   <= cfg_wdata[spi_pkg::MAXSPD_W-1:0];
          spi_pkg::CFG_BAND:  band_r  <= cfg_wdata[spi_pkg::BAND_W-1:0];
        endcase
      end
    end
  end

  // Working registers carry no reset: each is loaded before the step that reads it.
  always_ff @(posedge clk) begin
    if (acc) begin
      hc_r    <= hc;
      mb_r    <= max_back;
      few_r   <= (fill_r < FW'(2));
      stop_r  <= (spd_mag < SPW'(band_r));
      rim_r   <= ((hc == '0) && spd_pos) || ((hc == max_back) && spd_neg);
      jprod_r <= $signed(in_ch.jog_ticks) * $signed({1'b0, gain_r});
      jz_r    <= (in_ch.jog_ticks == '0);
    end
    if (state_r == S_R1) begin
      frac_r  <= frac;
      dprod_r <= DP_W'(spd_mag) * DP_W'(decay_r);
      nh_r    <= $signed({2'b00, hc_r}) - (HW+2)'(speed_r);
    end
  end

  spi_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk    (clk),
    .we     (hist_we),
    .waddr  (wp_r),
    .wdata  ({in_ch.push_left, in_ch.push_right}),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  spi_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk   (clk),
    .frac  (frac_r),
    .word0 (rdata0),
    .word1 (rdata1),
    .left  (bl_left),
    .right (bl_right)
  );

  spi_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .room      (q_room),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  a_room_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R3) |-> q_room)
    else $error("render finished with no room in the result queue");

  a_head_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_R3) && !few_r && !stop_r) |-> (head_r <= mb_r))
    else $error("head left the window after a render");

  a_fill_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_we && (fill_r != FILL_FULL)) |=> (fill_r == FW'($past(fill_r) + 1'b1)))
    else $error("fill count did not follow a stored frame");

  a_idle_between: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("word taken while a multi-cycle item is in flight");
`endif

endmodule

`default_nettype wire

>>> verif/playhead_checker.sv
`timescale 1ns / 1ps
// Checker for the scratch playhead interpolator: it predicts one result word for every
// accepted input word and compares each accepted result word with the oldest prediction.
// Depends on spi_pkg, spi_in_if and spi_out_if.

module playhead_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  spi_in_if                              in_ch,
  spi_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [spi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             due,
  output int                             compared,
  output int                             audible_count
);
  import spi_pkg::*;

  localparam int     DEPTH = HISTORY_DEPTH_DEF;
  localparam int     FRAC  = FRAC_BITS_DEF;
  localparam longint ONE   = longint'(1) << FRAC;

  logic [FRAME_W-1:0]        history [DEPTH];
  int                        wr_pos;
  int                        frames_held;
  logic [HEAD_W-1:0]         head;
  logic signed [SPEED_W-1:0] velocity;
  logic                      scratching;
  logic [GAIN_W-1:0]         gain;
  logic [DECAY_W-1:0]        decay;
  logic [MAXSPD_W-1:0]       vmax;
  logic [BAND_W-1:0]         band;
  res_t                      due_words [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Magnitude is scaled, truncated and saturated, then the sign is put back.
  function automatic logic signed [SPEED_W-1:0] decayed(input logic signed [SPEED_W-1:0] v);
    longint mag;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    mag = (mag * longint'(decay)) >>> DECAY_SHIFT;
    if (mag > longint'(SPEED_SAT))
      mag = longint'(SPEED_SAT);
    return (v < 0) ? SPEED_W'(-mag) : SPEED_W'(mag);
  endfunction

  task automatic advance_playhead(input logic [KIND_W-1:0] kind,
                                  input logic [SAMPLE_W-1:0] pl, pr, jt,
                                  input logic [SEED_W-1:0] sp, output res_t w);
    longint top, pos, frac, v;
    int     k0;
    logic [FRAME_W-1:0] f0, f1;
    w = '0;
    case (kind)
      KIND_PUSH: begin
        history[wr_pos] = {pl, pr};
        wr_pos = (wr_pos + 1) % DEPTH;
        if (frames_held < DEPTH)
          frames_held++;
      end
      KIND_JOG: begin
        if (jt != '0) begin
          v = longint'(velocity) + longint'($signed(jt)) * longint'(gain);
          if (v > longint'(vmax))
            v = longint'(vmax);
          else if (v < -longint'(vmax))
            v = -longint'(vmax);
          velocity = SPEED_W'(v);
        end
      end
      KIND_SEED: begin
        head = ($signed(sp) < 0) ? '0 : sp[HEAD_W-1:0];
        velocity = '0;
        scratching = 1'b1;
      end
      KIND_END: begin
        scratching = 1'b0;
        velocity = '0;
      end
      KIND_RENDER: begin
        if (!scratching) begin
        end else if (frames_held < 2) begin
          velocity = decayed(velocity);
        end else if (longint'(velocity) > -longint'(band) &&
                     longint'(velocity) < longint'(band)) begin
          velocity = '0;
        end else begin
          top = longint'(frames_held - 1) << FRAC;
          if (top > longint'(HEAD_ALL))
            top = longint'(HEAD_ALL);
          pos = longint'(head);
          if (pos > top)
            pos = top;
          // At either end of the window, moving outwards, the step stays silent.
          if (!((pos <= 0 && velocity > 0) || (pos >= top && velocity < 0))) begin
            k0 = int'(pos >> FRAC);
            frac = pos & (ONE - 1);
            if (k0 >= frames_held - 1) begin
              k0 = frames_held - 2;
              frac = ONE;
            end
            f0 = history[(wr_pos + DEPTH - 1 - k0) % DEPTH];
            f1 = history[(wr_pos + DEPTH - 2 - k0) % DEPTH];
            w.left_out = SAMPLE_W'(((ONE - frac) * longint'($signed(f0[31:16])) +
                                    frac * longint'($signed(f1[31:16]))) / ONE);
            w.right_out = SAMPLE_W'(((ONE - frac) * longint'($signed(f0[15:0])) +
                                     frac * longint'($signed(f1[15:0]))) / ONE);
            w.audible = 1'b1;
          end
          pos = pos - longint'(velocity);
          if (pos < 0)
            pos = 0;
          else if (pos > top)
            pos = top;
          head = pos[HEAD_W-1:0];
          velocity = decayed(velocity);
        end
      end
      default: begin
      end
    endcase
    w.engaged = scratching;
    w.head_position = head;
  endtask

  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      wr_pos = 0;
      frames_held = 0;
      head = '0;
      velocity = '0;
      scratching = 1'b0;
      gain = GAIN_RST;
      decay = DECAY_RST;
      vmax = MAX_RST;
      band = BAND_RST;
      due_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:  gain = cfg_wdata[GAIN_W-1:0];
          CFG_DECAY: decay = cfg_wdata[DECAY_W-1:0];
          CFG_MAX:   vmax = cfg_wdata[MAXSPD_W-1:0];
          CFG_BAND:  band = cfg_wdata[BAND_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_playhead(in_ch.kind, in_ch.push_left, in_ch.push_right, in_ch.jog_ticks,
                         in_ch.seed_position, want);
        due_words.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.left_out = out_ch.left_out;
        got.right_out = out_ch.right_out;
        got.audible = out_ch.audible;
        got.engaged = out_ch.engaged;
        got.head_position = out_ch.head_position;
        compared++;
        if (due_words.size() == 0) begin
          report_mismatch("result word with none outstanding", 1, 0);
        end else begin
          want = due_words.pop_front();
          if (want.audible)
            audible_count++;
          if (got.left_out !== want.left_out)
            report_mismatch("left_out", got.left_out, want.left_out);
          if (got.right_out !== want.right_out)
            report_mismatch("right_out", got.right_out, want.right_out);
          if (got.audible !== want.audible)
            report_mismatch("audible", got.audible, want.audible);
          if (got.engaged !== want.engaged)
            report_mismatch("engaged", got.engaged, want.engaged);
          if (got.head_position !== want.head_position)
            report_mismatch("head_position", got.head_position, want.head_position);
        end
      end
    end
    due = due_words.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the scratch playhead interpolator: clock, reset, stimulus, register
// writes and the verdict. Depends on spi_pkg, both channel interfaces and playhead_checker.

module tb;
  import spi_pkg::*;

  localparam int DEPTH       = HISTORY_DEPTH_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_WORDS = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  spi_in_if  in_ch ();
  spi_out_if out_ch ();

  int mismatches, due, compared, audible_count;
  int n_sent, pushed, n_settings, quiet;
  bit idle_on, hold_out;

  scratch_playhead_interpolator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  playhead_checker check_u (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .due           (due),
    .compared      (compared),
    .audible_count (audible_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
      quiet <= quiet + 1;
    else
      quiet <= 0;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls while idling is on, plus one long hold-off when asked for.
  initial begin : result_sink
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_ticks();
    logic [SAMPLE_W-1:0] t;
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return SAMPLE_W'($urandom);
      default: begin
        t = SAMPLE_W'($urandom_range(1, 60));
        return $urandom_range(0, 1) ? -t : t;
      end
    endcase
  endfunction

  // Seeds mostly land inside the current window, sometimes on or beyond its ends.
  function automatic logic [SEED_W-1:0] pick_seed();
    longint span;
    logic [SEED_W-1:0] s;
    span = (pushed > 0) ? longint'((pushed < DEPTH ? pushed : DEPTH) - 1) << FRAC : 0;
    s[HEAD_W-1:0] = $urandom;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = span[SEED_W-1:0];
      2:       s[SEED_W-1] = 1'b1;
      3:       s[SEED_W-1] = 1'b0;
      4:       s = SEED_W'(span - longint'($urandom_range(0, 65535)));
      default: s = {1'b0, HEAD_W'($urandom_range(span[HEAD_W-1:0], 0))};
    endcase
    return s;
  endfunction

  // Fields that the kind does not use still carry random values.
  task automatic send(input logic [KIND_W-1:0] kind, input logic [SEED_W-1:0] a,
                      input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] pl, pr, jt;
    logic [SEED_W-1:0]   sp;
    pl = $urandom;
    pr = $urandom;
    jt = $urandom;
    sp[HEAD_W-1:0] = $urandom;
    sp[SEED_W-1] = $urandom_range(0, 1);
    case (kind)
      KIND_PUSH: begin
        pl = a[SAMPLE_W-1:0];
        pr = b;
        pushed++;
      end
      KIND_JOG:  jt = a[SAMPLE_W-1:0];
      KIND_SEED: sp = a;
      default: begin
      end
    endcase
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.push_left <= pl;
    in_ch.push_right <= pr;
    in_ch.jog_ticks <= jt;
    in_ch.seed_position <= sp;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  // Stop offering words and let every outstanding result word come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (due != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic load_cfg(input logic [CFG_DATA_W-1:0] g, d, m, b);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_MAX, m);
    write_reg(CFG_BAND, b);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // A scratch gesture: fill some history, seed, jog, then mostly renders with noise mixed in.
  task automatic scenario();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 24);
    repeat (n) send(KIND_PUSH, pick_sample(), pick_sample());
    send(KIND_SEED, pick_seed(), '0);
    send(KIND_JOG, pick_ticks(), '0);
    n = $urandom_range(5, 30);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: send(KIND_JOG, pick_ticks(), '0);
        3:       send(KIND_PUSH, pick_sample(), pick_sample());
        4:       send(KIND_SEED, pick_seed(), '0);
        5:       send(KIND_RENDER + KIND_W'($urandom_range(1, 3)), '0, '0);
        6:       send(KIND_END, '0, '0);
        default: send(KIND_RENDER, '0, '0);
      endcase
    end
    if ($urandom_range(0, 1))
      send(KIND_END, '0, '0);
  endtask

  initial begin : stimulus
    int target;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_PUSH;
    in_ch.push_left <= '0;
    in_ch.push_right <= '0;
    in_ch.jog_ticks <= '0;
    in_ch.seed_position <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GAIN;
    cfg_wdata <= '0;
    idle_on = 1'b1;
    n_settings = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, on the reset register values.
    send(KIND_RENDER, '0, '0);
    send(KIND_JOG, 1, '0);
    send(KIND_JOG, 0, '0);
    send(KIND_END, '0, '0);
    for (int k = 1; k <= 3; k++)
      send(KIND_RENDER + KIND_W'(k), '0, '0);
    send(KIND_SEED, 33'h1_0000_0000, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_PUSH, 16'h7FFF, 16'h8000);
    send(KIND_JOG, 5, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_PUSH, 16'h8000, 16'h7FFF);
    send(KIND_PUSH, 16'hFFFF, 16'h0001);
    send(KIND_SEED, 33'h0_FFFF_FFFF, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_JOG, 16'h8000, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_JOG, 16'h7FFF, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_SEED, 33'h0_0001_8000, '0);
    send(KIND_JOG, 10, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_JOG, -30, '0);
    send(KIND_RENDER, '0, '0);
    send(KIND_END, '0, '0);
    settle();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: load_cfg(23'd4194304, 23'd65536, 23'd4194304, 23'd0);
        2: load_cfg(23'd0, 23'd0, 23'd0, 23'd65536);
        3: load_cfg(23'd1, 23'd65535, 23'd1, 23'd1);
        6: load_cfg($urandom_range(0, 4194304), $urandom_range(0, 65536),
                    $urandom_range(0, 4194304), $urandom_range(0, 65536));
        default: load_cfg($urandom_range(500, 40000), $urandom_range(60000, 65536),
                          $urandom_range(32768, 1048576), $urandom_range(0, 4000));
      endcase
      idle_on = (ph != 3);
      // The result side holds off for a long stretch while words keep being offered.
      if (ph == 4)
        hold_out = 1'b1;
      target = n_sent + PHASE_WORDS;
      while (n_sent < target)
        scenario();
      settle();
    end

    // Fill the whole history so that the write position wraps, then scratch across it.
    idle_on = 1'b0;
    load_cfg($urandom_range(20000, 4194304), $urandom_range(64000, 65536), 23'd4194304,
             $urandom_range(0, 2000));
    repeat (DEPTH + 40) send(KIND_PUSH, pick_sample(), pick_sample());
    target = n_sent + PHASE_WORDS;
    while (n_sent < target)
      scenario();
    settle();

    // Closing stretch on the reset values, with no idling on either side.
    load_cfg(GAIN_RST, DECAY_RST, MAX_RST, BAND_RST);
    target = n_sent + 60;
    while (n_sent < target)
      scenario();
    settle();

    $display("Sent %0d input words under %0d register settings, including a full history wrap.",
             n_sent, n_settings);
    $display("Compared %0d result words, %0d of them audible; %0d mismatches.",
             compared, audible_count, mismatches);
    if (mismatches == 0 && due == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/spi_pkg.sv
hw/rtl/spi_in_if.sv
hw/rtl/spi_out_if.sv
hw/rtl/spi_hist.sv
hw/rtl/spi_blend.sv
hw/rtl/spi_outq.sv
hw/rtl/scratch_playhead_interpolator.sv
verif/playhead_checker.sv
verif/tb.sv
